// ===== rtl/fsp_pkg.sv =====
// shared types, register codes and default sizes for the fourier-shift phase ramp
// no dependencies; used by fsp_trig and fourier_shift_phase_ramp
`timescale 1ns / 1ps

package fsp_pkg;

  // default module parameters
  localparam int MAX_DIM_LOG2_DEF = 12;
  localparam int PHASE_BITS_DEF   = 16;

  // pipeline shape: four phase stages then nine trig stages
  localparam int PIPE_DEPTH  = 13;
  localparam int TRIG_DEPTH  = 9;

  // index and frequency widths
  localparam int IDX_W = 12;
  localparam int K_W   = IDX_W + 1;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam int DISP_W     = 24;

  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH_LOG2  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT_LOG2 = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DISP_H      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DISP_V      = 2'd3;

  localparam logic [3:0] WIDTH_LOG2_RST  = 4'd8;
  localparam logic [3:0] HEIGHT_LOG2_RST = 4'd8;

  // input beat
  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
  } in_data_t;

  // result beat
  typedef struct packed {
    logic signed [15:0] real_part;
    logic signed [15:0] imag_part;
  } out_data_t;

endpackage

// ===== rtl/fsp_trig.sv =====
// nine-stage sine/cosine pipeline: octant residual to Q1.15 complex factor
// depends on fsp_pkg; load enables come from the valid chain in the top level
`timescale 1ns / 1ps

module fsp_trig #(
  parameter int PHASE_BITS = fsp_pkg::PHASE_BITS_DEF
) (
  input  logic                          clk,
  input  logic [fsp_pkg::TRIG_DEPTH-1:0] ld,
  input  logic [PHASE_BITS-3:0]         ar_in,
  input  logic [1:0]                    quad_in,
  input  logic                          rneg_in,
  input  logic                          mid_in,
  output fsp_pkg::out_data_t            out_data
);

  localparam int PB = PHASE_BITS;

  // 2*pi in Q28 and one in Q30
  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

  // exact reciprocals for x < 2^30: ceil(2^(30+l)/d), 2^(l-1) < d <= 2^l
  localparam int          SH42  = 36;
  localparam logic [30:0] RCP42 = 31'(((64'd1 << SH42) + 64'd41) / 64'd42);
  localparam int          SH56  = 36;
  localparam logic [30:0] RCP56 = 31'(((64'd1 << SH56) + 64'd55) / 64'd56);
  localparam int          SH20  = 35;
  localparam logic [30:0] RCP20 = 31'(((64'd1 << SH20) + 64'd19) / 64'd20);
  localparam int          SH30  = 35;
  localparam logic [30:0] RCP30 = 31'(((64'd1 << SH30) + 64'd29) / 64'd30);
  localparam int          SH6   = 33;
  localparam logic [30:0] RCP6  = 31'(((64'd1 << SH6) + 64'd5) / 64'd6);
  localparam int          SH12  = 34;
  localparam logic [30:0] RCP12 = 31'(((64'd1 << SH12) + 64'd11) / 64'd12);

  typedef struct packed {
    logic [1:0] quad;
    logic       rneg;
    logic       mid;
  } side_t;

  // quotient by a constant through its reciprocal
  function automatic logic [29:0] div_rcp(input logic [29:0] x, input logic [30:0] m,
                                          input int sh);
    logic [60:0] pr;
    pr = x * m;
    return 30'(pr >> sh);
  endfunction

  // Q30 product, result no larger than x since y <= 1.0
  function automatic logic [29:0] qmul(input logic [29:0] x, input logic [30:0] y);
    logic [60:0] pr;
    pr = x * y;
    return pr[59:30];
  endfunction

  // Q30 to Q15, round half up, saturate
  function automatic logic [14:0] to_q15(input logic [30:0] x);
    logic [16:0] v;
    v = 17'((x + 31'd16384) >> 15);
    return (v > 17'd32767) ? 15'd32767 : v[14:0];
  endfunction

  side_t       side_r [fsp_pkg::TRIG_DEPTH-1];
  logic [29:0] a_r    [7];
  logic [29:0] a2_r   [6];
  logic [30:0] s7_r, c7_r, s9_r, c9_r, s11_r, c11_r;
  logic [29:0] s8_r, c8_r, s10_r, c10_r, s12_r, c12_r;
  fsp_pkg::out_data_t out_r;

  logic [PB+28:0] ang_prod;
  logic [59:0]    sq_prod;
  logic [30:0]    c_fin;
  logic [14:0]    s_q15, c_q15;
  logic signed [15:0] sv, cv;
  fsp_pkg::out_data_t out_nxt;

  // side info travels with each stage
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      side_r[0] <= '{quad: quad_in, rneg: rneg_in, mid: mid_in};
    end
    for (int i = 1; i < fsp_pkg::TRIG_DEPTH - 1; i++) begin
      if (ld[i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // stage 5: residual to radians in Q30
  assign ang_prod = ar_in * TWO_PI_Q28;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      a_r[0] <= ang_prod[PB+27:PB-2];
    end
  end

  // stage 6: angle squared
  assign sq_prod = a_r[0] * a_r[0];

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      a_r[1]  <= a_r[0];
      a2_r[0] <= sq_prod[59:30];
    end
  end

  // stage 7: innermost horner terms
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      a_r[2]  <= a_r[1];
      a2_r[1] <= a2_r[0];
      s7_r    <= ONE_Q30 - {1'b0, div_rcp(a2_r[0], RCP42, SH42)};
      c7_r    <= ONE_Q30 - {1'b0, div_rcp(a2_r[0], RCP56, SH56)};
    end
  end

  // stage 8: multiply by angle squared
  always_ff @(posedge clk) begin
    if (ld[3]) begin
      a_r[3]  <= a_r[2];
      a2_r[2] <= a2_r[1];
      s8_r    <= qmul(a2_r[1], s7_r);
      c8_r    <= qmul(a2_r[1], c7_r);
    end
  end

  // stage 9: divide by 20 and 30
  always_ff @(posedge clk) begin
    if (ld[4]) begin
      a_r[4]  <= a_r[3];
      a2_r[3] <= a2_r[2];
      s9_r    <= ONE_Q30 - {1'b0, div_rcp(s8_r, RCP20, SH20)};
      c9_r    <= ONE_Q30 - {1'b0, div_rcp(c8_r, RCP30, SH30)};
    end
  end

  // stage 10: multiply by angle squared
  always_ff @(posedge clk) begin
    if (ld[5]) begin
      a_r[5]  <= a_r[4];
      a2_r[4] <= a2_r[3];
      s10_r   <= qmul(a2_r[3], s9_r);
      c10_r   <= qmul(a2_r[3], c9_r);
    end
  end

  // stage 11: divide by 6 and 12
  always_ff @(posedge clk) begin
    if (ld[6]) begin
      a_r[6]  <= a_r[5];
      a2_r[5] <= a2_r[4];
      s11_r   <= ONE_Q30 - {1'b0, div_rcp(s10_r, RCP6, SH6)};
      c11_r   <= ONE_Q30 - {1'b0, div_rcp(c10_r, RCP12, SH12)};
    end
  end

  // stage 12: sine times angle, last cosine product
  always_ff @(posedge clk) begin
    if (ld[7]) begin
      s12_r  <= qmul(a_r[6], s11_r);
      c12_r  <= qmul(a2_r[5], c11_r);
    end
  end

  // stage 13: round, rotate by quadrant, clear imaginary part at centre
  always_comb begin
    c_fin = ONE_Q30 - 31'(c12_r >> 1);
    s_q15 = to_q15({1'b0, s12_r});
    c_q15 = to_q15(c_fin);
    sv    = side_r[7].rneg ? -$signed({1'b0, s_q15}) : $signed({1'b0, s_q15});
    cv    = $signed({1'b0, c_q15});
    case (side_r[7].quad)
      2'd0: begin
        out_nxt.real_part = cv;
        out_nxt.imag_part = sv;
      end
      2'd1: begin
        out_nxt.real_part = -sv;
        out_nxt.imag_part = cv;
      end
      2'd2: begin
        out_nxt.real_part = -cv;
        out_nxt.imag_part = -sv;
      end
      default: begin
        out_nxt.real_part = sv;
        out_nxt.imag_part = -cv;
      end
    endcase
    if (side_r[7].mid) begin
      out_nxt.imag_part = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// ===== rtl/fourier_shift_phase_ramp.sv =====
// top level of the fourier-shift phase ramp: config registers, phase stages, valid chain
// depends on fsp_pkg and fsp_trig
`timescale 1ns / 1ps

// Takes one (col, row) coordinate a beat and returns exp(2*pi*i*(dh*kh/Nh + dv*kv/Nv))
// as Q1.15 real and imaginary parts. A new beat is accepted every clock unless the
// pipeline is full and the output stalls; a beat's result passes through thirteen
// register stages, the first loaded on acceptance:
// four for frequency index, displacement products, phase sum and octant fold, then
// nine for the radian conversion, squaring and the Horner chain of the sine/cosine
// polynomials. Bubbles in the pipeline are closed up under an output stall, so beats
// keep being taken while a result waits. The user must write sizes and displacements
// only while the block holds no beat; the block itself does not enforce this.

module fourier_shift_phase_ramp #(
  parameter int MAX_DIM_LOG2 = fsp_pkg::MAX_DIM_LOG2_DEF,
  parameter int PHASE_BITS   = fsp_pkg::PHASE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  fsp_pkg::in_data_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output fsp_pkg::out_data_t                 out_data,
  input  logic                               cfg_we,
  input  logic [fsp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [fsp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int LW       = $clog2(MAX_DIM_LOG2 + 1);
  localparam int FB       = 16 + MAX_DIM_LOG2;
  localparam int PB       = PHASE_BITS;
  localparam int SD       = (FB > PB) ? FB - PB - 1 : 0;
  localparam int SU       = (PB > FB) ? PB - FB : 0;
  localparam int EIGHTH_I = 1 << (PB - 3);
  localparam int DEPTH    = fsp_pkg::PIPE_DEPTH;
  localparam int TDEPTH   = fsp_pkg::TRIG_DEPTH;
  localparam int K_W      = fsp_pkg::K_W;
  localparam int PROD_W   = fsp_pkg::DISP_W + K_W;
  localparam logic [PB-3:0] EIGHTH = (PB-2)'(EIGHTH_I);

  // clamp a size register into 1 .. MAX_DIM_LOG2
  function automatic logic [LW-1:0] eff_log2(input logic [3:0] v);
    if (v == 4'd0) begin
      return LW'(1);
    end else if (int'(v) > MAX_DIM_LOG2) begin
      return LW'(MAX_DIM_LOG2);
    end else begin
      return LW'(v);
    end
  endfunction

  // signed frequency index of idx modulo 2^lg, with the centre flag on top
  function automatic logic [K_W:0] freq_idx(input logic [fsp_pkg::IDX_W-1:0] idx,
                                            input logic [LW-1:0] lg);
    logic [K_W-1:0] x;
    logic [K_W-1:0] k;
    logic           hb;
    logic           lowz;
    x    = {1'b0, idx};
    hb   = 1'b0;
    lowz = 1'b1;
    for (int j = 0; j < K_W; j++) begin
      if (j == int'(lg) - 1) begin
        hb = x[j];
      end
      if (j < int'(lg) - 1 && x[j]) begin
        lowz = 1'b0;
      end
    end
    for (int j = 0; j < K_W; j++) begin
      k[j] = (j < int'(lg)) ? x[j] : hb;
    end
    return {hb && lowz, k};
  endfunction

  // configuration registers
  logic [3:0]                        wlog_r, hlog_r;
  logic signed [fsp_pkg::DISP_W-1:0] disp_h_r, disp_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlog_r   <= fsp_pkg::WIDTH_LOG2_RST;
      hlog_r   <= fsp_pkg::HEIGHT_LOG2_RST;
      disp_h_r <= '0;
      disp_v_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        fsp_pkg::REG_WIDTH_LOG2:  wlog_r   <= cfg_wdata[3:0];
        fsp_pkg::REG_HEIGHT_LOG2: hlog_r   <= cfg_wdata[3:0];
        fsp_pkg::REG_DISP_H:      disp_h_r <= cfg_wdata[fsp_pkg::DISP_W-1:0];
        fsp_pkg::REG_DISP_V:      disp_v_r <= cfg_wdata[fsp_pkg::DISP_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LW-1:0] lh, lv, sh_h, sh_v;

  assign lh   = eff_log2(wlog_r);
  assign lv   = eff_log2(hlog_r);
  assign sh_h = LW'(MAX_DIM_LOG2) - lh;
  assign sh_v = LW'(MAX_DIM_LOG2) - lv;

  // valid chain: a stage loads when it is empty or the next one moves
  logic [DEPTH-1:0] v_r, v_nxt;
  logic [DEPTH:0]   rdy;

  always_comb begin
    rdy[DEPTH] = !out_stall;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int i = 1; i < DEPTH; i++) begin
      v_nxt[i] = rdy[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[DEPTH-1];

  // stage 1: frequency indices and centre flag
  logic [K_W:0]          fh, fv;
  logic signed [K_W-1:0] k_h_r, k_v_r;
  logic [3:0]            mid_r;

  assign fh = freq_idx(in_data.col, lh);
  assign fv = freq_idx(in_data.row, lv);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      k_h_r    <= fh[K_W-1:0];
      k_v_r    <= fv[K_W-1:0];
      mid_r[0] <= fh[K_W] && fv[K_W];
    end
    for (int i = 1; i < 4; i++) begin
      if (rdy[i]) begin
        mid_r[i] <= mid_r[i-1];
      end
    end
  end

  // stage 2: displacement times frequency index, kept modulo one turn
  logic signed [PROD_W-1:0] prod_h_full, prod_v_full;
  logic [FB-1:0]            prod_h_r, prod_v_r;

  assign prod_h_full = disp_h_r * k_h_r;
  assign prod_v_full = disp_v_r * k_v_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      prod_h_r <= prod_h_full[FB-1:0];
      prod_v_r <= prod_v_full[FB-1:0];
    end
  end

  // stage 3: scale each term to the common fraction and sum
  logic [FB-1:0] th, tv, frac_r;

  assign th = prod_h_r << sh_h;
  assign tv = prod_v_r << sh_v;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      frac_r <= th + tv;
    end
  end

  // stage 4: round to phase bits, centre on the octant, fold to magnitude
  logic [FB:0]   rnd;
  logic [PB-1:0] ph, pe;
  logic [PB-3:0] lowv, ar_nxt, ar_r;
  logic [1:0]    quad_r;
  logic          rneg_nxt, rneg_r;

  always_comb begin
    if (FB > PB) begin
      rnd = ({1'b0, frac_r} >> SD) + (FB+1)'(1);
      ph  = PB'(rnd >> 1);
    end else begin
      rnd = '0;
      ph  = PB'(frac_r) << SU;
    end
    pe       = ph + PB'(EIGHTH_I);
    lowv     = pe[PB-3:0];
    rneg_nxt = lowv < EIGHTH;
    ar_nxt   = rneg_nxt ? EIGHTH - lowv : lowv - EIGHTH;
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      ar_r   <= ar_nxt;
      quad_r <= pe[PB-1:PB-2];
      rneg_r <= rneg_nxt;
    end
  end

  // stages 5 to 13: sine and cosine
  fsp_trig #(
    .PHASE_BITS (PHASE_BITS)
  ) u_trig (
    .clk      (clk),
    .ld       (rdy[DEPTH-1:DEPTH-TDEPTH]),
    .ar_in    (ar_r),
    .quad_in  (quad_r),
    .rneg_in  (rneg_r),
    .mid_in   (mid_r[3]),
    .out_data (out_data)
  );

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&v_r) && out_stall))
    else $error("input stalled with room in the pipeline");

  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted beat not held in first stage");

  a_residual_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] |-> (ar_r <= EIGHTH))
    else $error("octant residual beyond one eighth turn");

  a_out_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.real_part != -16'sd32768 && out_data.imag_part != -16'sd32768))
    else $error("result outside saturation range");

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the fourier-shift phase ramp
// depends on fsp_pkg and fourier_shift_phase_ramp; a local predictor checks every beat
`timescale 1ns / 1ps

module testbench;

  localparam int DIM_LOG2    = fsp_pkg::MAX_DIM_LOG2_DEF;
  localparam int PHASE_W     = fsp_pkg::PHASE_BITS_DEF;
  localparam int FRAC_W      = 16 + DIM_LOG2;
  localparam int IDX_W       = fsp_pkg::IDX_W;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOWN_ERRS  = 10;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quadrant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fsp_pkg::in_data_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fsp_pkg::out_data_t out_data;
  logic cfg_we = 1'b0;
  logic [fsp_pkg::CFG_ADDR_W-1:0] cfg_addr = fsp_pkg::REG_WIDTH_LOG2;
  logic [fsp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor copy of the registers
  logic [3:0] size_h_log2 = fsp_pkg::WIDTH_LOG2_RST;
  logic [3:0] size_v_log2 = fsp_pkg::HEIGHT_LOG2_RST;
  logic signed [fsp_pkg::DISP_W-1:0] shift_h = '0;
  logic signed [fsp_pkg::DISP_W-1:0] shift_v = '0;

  fsp_pkg::out_data_t expected_factors[$];
  int error_count = 0;
  int unsigned cycle_count = 0;
  bit no_idle = 1'b0;

  fourier_shift_phase_ramp dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // size register clamped to the supported range
  function automatic int unsigned eff_size_log2(input logic [3:0] v);
    if (v < 1) return 1;
    if (v > DIM_LOG2) return DIM_LOG2;
    return v;
  endfunction

  // signed frequency bin of an index modulo 2^lg
  function automatic longint signed_bin(input logic [IDX_W-1:0] idx, input int unsigned lg,
                                        output logic at_mid);
    longint n;
    longint m;
    n = longint'(1) << lg;
    m = longint'(idx) & (n - 1);
    at_mid = (m == n / 2);
    return (m < n / 2) ? m : m - n;
  endfunction

  function automatic logic [15:0] to_q15(input logic [63:0] v);
    logic [63:0] t;
    t = (v + 64'd16384) >> 15;
    return (t > 64'd32767) ? 16'd32767 : t[15:0];
  endfunction

  // expected phase factor for one coordinate under the current registers
  function automatic fsp_pkg::out_data_t phase_factor(input fsp_pkg::in_data_t coord);
    int unsigned lh, lv;
    logic mid_h, mid_v, rneg;
    longint kh, kv, r;
    logic [63:0] th, tv, frac, p, pe, ar, a, a2, s, c;
    logic signed [15:0] sv, cv;
    fsp_pkg::out_data_t res;
    lh = eff_size_log2(size_h_log2);
    lv = eff_size_log2(size_v_log2);
    kh = signed_bin(coord.col, lh, mid_h);
    kv = signed_bin(coord.row, lv, mid_v);
    th = longint'(shift_h) * kh;
    tv = longint'(shift_v) * kv;
    th = th << (DIM_LOG2 - lh);
    tv = tv << (DIM_LOG2 - lv);
    frac = (th + tv) & ((64'd1 << FRAC_W) - 1);

    // round the phase to the trig phase width
    if (FRAC_W > PHASE_W) p = ((frac >> (FRAC_W - PHASE_W - 1)) + 1) >> 1;
    else p = frac << (PHASE_W - FRAC_W);
    p &= (64'd1 << PHASE_W) - 1;

    // fold into an octant around the quadrant axis
    pe = (p + (64'd1 << (PHASE_W - 3))) & ((64'd1 << PHASE_W) - 1);
    r = longint'(pe & ((64'd1 << (PHASE_W - 2)) - 1)) - (longint'(1) << (PHASE_W - 3));
    rneg = (r < 0);
    ar = rneg ? -r : r;
    a = (ar * 64'd1686629713) >> (PHASE_W - 2);
    a2 = (a * a) >> 30;

    // taylor polynomials in q30
    s = (64'd1 << 30) - a2 / 64'd42;
    s = (64'd1 << 30) - ((a2 * s) >> 30) / 64'd20;
    s = (64'd1 << 30) - ((a2 * s) >> 30) / 64'd6;
    s = (a * s) >> 30;
    c = (64'd1 << 30) - a2 / 64'd56;
    c = (64'd1 << 30) - ((a2 * c) >> 30) / 64'd30;
    c = (64'd1 << 30) - ((a2 * c) >> 30) / 64'd12;
    c = (64'd1 << 30) - ((a2 * c) >> 30) / 64'd2;

    sv = to_q15(s);
    if (rneg) sv = -sv;
    cv = to_q15(c);

    case (quadrant_t'(pe[PHASE_W-1 -: 2]))
      QUAD_0: begin
        res.real_part = cv;
        res.imag_part = sv;
      end
      QUAD_1: begin
        res.real_part = -sv;
        res.imag_part = cv;
      end
      QUAD_2: begin
        res.real_part = -cv;
        res.imag_part = -sv;
      end
      default: begin
        res.real_part = sv;
        res.imag_part = -cv;
      end
    endcase
    if (mid_h && mid_v) res.imag_part = '0;
    return res;
  endfunction

  task automatic flag_error(input string what, input int exp_v, input int got_v);
    error_count++;
    if (error_count <= SHOWN_ERRS)
      $display("mismatch %0d: %s expected %0d got %0d", error_count, what, exp_v, got_v);
  endtask

  // record the expected factor of every accepted input beat
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) expected_factors.push_back(phase_factor(in_data));
  end

  // compare every accepted result beat with the oldest expectation
  always @(posedge clk) begin
    fsp_pkg::out_data_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_factors.size() == 0) begin
        flag_error("result with nothing pending, real part", 0, out_data.real_part);
      end else begin
        want = expected_factors.pop_front();
        if (out_data.real_part !== want.real_part)
          flag_error("real_part", want.real_part, out_data.real_part);
        if (out_data.imag_part !== want.imag_part)
          flag_error("imag_part", want.imag_part, out_data.imag_part);
      end
    end
  end

  // random output stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 33);
    end
  end

  // run-time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one input beat, with a random gap in front
  task automatic send_coord(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
    if (!no_idle && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 33);
    end
    in_valid <= 1'b1;
    in_data <= '{col: col, row: row};
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait until every result has come back
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_factors.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [fsp_pkg::CFG_ADDR_W-1:0] addr,
                          input logic [fsp_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // write all four registers back to back, block idle
  task automatic set_config(input logic [23:0] w, input logic [23:0] h,
                            input logic [23:0] dh, input logic [23:0] dv);
    cfg_beat(fsp_pkg::REG_WIDTH_LOG2, w);
    cfg_beat(fsp_pkg::REG_HEIGHT_LOG2, h);
    cfg_beat(fsp_pkg::REG_DISP_H, dh);
    cfg_beat(fsp_pkg::REG_DISP_V, dv);
    cfg_we <= 1'b0;
    size_h_log2 = w[3:0];
    size_v_log2 = h[3:0];
    shift_h = dh;
    shift_v = dv;
  endtask

  // size write with junk in the unused upper bits
  function automatic logic [23:0] pick_size();
    logic [3:0] v;
    case ($urandom_range(3))
      0: v = 4'($urandom_range(1, 4));
      1: case ($urandom_range(3))
           0: v = 4'd0;
           1: v = 4'd1;
           2: v = 4'd12;
           default: v = 4'd15;
         endcase
      default: v = 4'($urandom_range(0, 15));
    endcase
    return {20'($urandom()), v};
  endfunction

  function automatic logic [23:0] pick_disp();
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(4))
        0: return 24'h7FFFFF;
        1: return 24'h800000;
        2: return 24'h000000;
        3: return 24'h000001;
        default: return 24'hFFFFFF;
      endcase
    end
    return 24'($urandom());
  endfunction

  // reset values give a zero phase everywhere
  task automatic test_reset_values();
    send_coord(12'd0, 12'd0);
    send_coord(12'hFFF, 12'hFFF);
  endtask

  // 4x4 grid with phases on every eighth of a turn, centre included
  task automatic test_octant_grid();
    wait_all_results();
    set_config(24'd2, 24'd2, 24'h010000, 24'h008000);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        send_coord(IDX_W'(c), IDX_W'(r));
  endtask

  // largest sizes and displacements, then sizes outside the legal range
  task automatic test_field_extremes();
    wait_all_results();
    set_config(24'd12, 24'd12, 24'h7FFFFF, 24'h800000);
    send_coord(12'hFFF, 12'h000);
    send_coord(12'h800, 12'h800);
    send_coord(12'h7FF, 12'hFFF);
    wait_all_results();
    set_config(24'hFFFFF0, 24'h00000F, 24'h800000, 24'h7FFFFF);
    send_coord(12'hFFF, 12'hFFF);
    send_coord(12'h001, 12'h800);
  endtask

  // random settings, each followed by a run of random coordinates
  task automatic test_random_sweep();
    logic [IDX_W-1:0] col, row;
    int unsigned lh, lv;
    for (int ph = 0; ph < 8; ph++) begin
      wait_all_results();
      no_idle = (ph == 3);
      set_config(pick_size(), pick_size(), pick_disp(), pick_disp());
      lh = eff_size_log2(size_h_log2);
      lv = eff_size_log2(size_v_log2);
      for (int n = 0; n < 50; n++) begin
        col = IDX_W'($urandom());
        row = IDX_W'($urandom());
        // steer some beats onto the centre line of each axis
        if ($urandom_range(5) == 0) col = ((col >> lh) << lh) | IDX_W'(1 << (lh - 1));
        if ($urandom_range(5) == 0) row = ((row >> lv) << lv) | IDX_W'(1 << (lv - 1));
        send_coord(col, row);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_octant_grid();
    test_field_extremes();
    test_random_sweep();

    // drain, then let the pipeline run empty
    wait_all_results();
    repeat (fsp_pkg::PIPE_DEPTH + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fsp_pkg.sv
rtl/fsp_trig.sv
rtl/fourier_shift_phase_ramp.sv
sim/testbench.sv
